// ===== src/via_pkg.sv =====
// Package for the interface adapter: beat types, function codes, register addresses.
package via_pkg;

    // Function codes carried in the func field
    localparam logic [2:0] FUNC_WRITE = 3'd0;
    localparam logic [2:0] FUNC_READ  = 3'd1;
    localparam logic [2:0] FUNC_PIN_A = 3'd2;
    localparam logic [2:0] FUNC_PIN_B = 3'd3;
    localparam logic [2:0] FUNC_CA1   = 3'd4;

    // Register map on the bus
    localparam logic [3:0] ADDR_PORT_B = 4'h0;
    localparam logic [3:0] ADDR_PORT_A = 4'h1;
    localparam logic [3:0] ADDR_DIR_B  = 4'h2;
    localparam logic [3:0] ADDR_DIR_A  = 4'h3;
    localparam logic [3:0] ADDR_PCR    = 4'hC;
    localparam logic [3:0] ADDR_IFR    = 4'hD;
    localparam logic [3:0] ADDR_IER    = 4'hE;

    // Flag and enable masks
    localparam logic [7:0] FLAG_IRQ_CA1 = 8'b1000_0010;
    localparam logic [7:0] FLAG_KEEP    = 8'b0111_1101;
    localparam logic [7:0] ENABLE_CA1   = 8'b0000_0010;
    localparam int         IER_SET_BIT  = 7;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] reg_addr;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic       irq_request;
        logic       irq_release;
        logic       bad_register;
    } out_item_t;

endpackage

// ===== src/via_in_reg.sv =====
// Input register stage: captures one beat and holds it until the core takes it.
module via_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  via_pkg::in_item_t  item,
    input  logic               take,
    output logic               stage_valid,
    output via_pkg::in_item_t  stage_item
);
    import via_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Accept a new beat when empty or when the held one moves on
    assign item_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
            valid_next = item_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== src/via_core.sv =====
// Adapter core: register file and single-pass decode of one beat.
module via_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  via_pkg::in_item_t  item,
    output via_pkg::out_item_t result_next
);
    import via_pkg::*;

    logic [7:0] port_a_reg, port_a_next;
    logic [7:0] port_b_reg, port_b_next;
    logic [7:0] dir_a_reg, dir_a_next;
    logic [7:0] dir_b_reg, dir_b_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] flag_reg, flag_next;
    logic [7:0] enable_reg, enable_next;

    logic [7:0] rd;
    logic       req;
    logic       rel;
    logic       bad;
    logic       ca1_set;

    // Both CA1 and IRQ flags set: a port A bus access clears them
    assign ca1_set = (flag_reg & FLAG_IRQ_CA1) == FLAG_IRQ_CA1;

    // Decode the beat and compute the next register values
    always_comb
    begin
        port_a_next = port_a_reg;
        port_b_next = port_b_reg;
        dir_a_next  = dir_a_reg;
        dir_b_next  = dir_b_reg;
        ctrl_next   = ctrl_reg;
        flag_next   = flag_reg;
        enable_next = enable_reg;
        rd  = 8'h00;
        req = 1'b0;
        rel = 1'b0;
        bad = 1'b0;
        unique case (item.func)
            FUNC_WRITE:
            begin
                unique case (item.reg_addr)
                    ADDR_PORT_B: port_b_next = item.data & dir_b_reg;
                    ADDR_PORT_A:
                    begin
                        port_a_next = item.data & dir_a_reg;
                        if (ca1_set)
                        begin
                            flag_next = flag_reg & FLAG_KEEP;
                            rel       = 1'b1;
                        end
                    end
                    ADDR_DIR_B:  dir_b_next = item.data;
                    ADDR_DIR_A:  dir_a_next = item.data;
                    ADDR_PCR:    ctrl_next  = item.data;
                    ADDR_IFR:    flag_next  = item.data;
                    ADDR_IER:
                    begin
                        if (item.data[IER_SET_BIT])
                            enable_next = enable_reg | item.data;
                        else
                            enable_next = enable_reg & ~item.data;
                    end
                    default:     bad = 1'b1;
                endcase
            end
            FUNC_READ:
            begin
                unique case (item.reg_addr)
                    ADDR_PORT_B: rd = port_b_reg & ~dir_b_reg;
                    ADDR_PORT_A:
                    begin
                        rd = port_a_reg & ~dir_a_reg;
                        if (ca1_set)
                        begin
                            flag_next = flag_reg & FLAG_KEEP;
                            rel       = 1'b1;
                        end
                    end
                    ADDR_DIR_B:  rd = dir_b_reg;
                    ADDR_DIR_A:  rd = dir_a_reg;
                    ADDR_PCR:    rd = ctrl_reg;
                    ADDR_IFR:    rd = flag_reg;
                    ADDR_IER:    rd = enable_reg;
                    default:     bad = 1'b1;
                endcase
            end
            FUNC_PIN_A: port_a_next = item.data & ~dir_a_reg;
            FUNC_PIN_B: port_b_next = item.data & ~dir_b_reg;
            FUNC_CA1:
            begin
                // Raise the flag when the level matches the selected edge and CA1 is enabled
                if ((item.data[0] == ctrl_reg[0]) && ((enable_reg & ENABLE_CA1) != 8'h00))
                begin
                    flag_next = flag_reg | FLAG_IRQ_CA1;
                    req       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Commit state only when the beat moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg <= 8'h00;
            port_b_reg <= 8'h00;
            dir_a_reg  <= 8'h00;
            dir_b_reg  <= 8'h00;
            ctrl_reg   <= 8'h00;
            flag_reg   <= 8'h00;
            enable_reg <= 8'h00;
        end
        else if (fire)
        begin
            port_a_reg <= port_a_next;
            port_b_reg <= port_b_next;
            dir_a_reg  <= dir_a_next;
            dir_b_reg  <= dir_b_next;
            ctrl_reg   <= ctrl_next;
            flag_reg   <= flag_next;
            enable_reg <= enable_next;
        end
    end

    assign result_next.read_data    = rd;
    assign result_next.port_a_out   = port_a_next;
    assign result_next.port_b_out   = port_b_next;
    assign result_next.irq_request  = req;
    assign result_next.irq_release  = rel;
    assign result_next.bad_register = bad;

endmodule

// ===== src/via_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
module via_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  via_pkg::out_item_t result_next,
    output logic               space,
    output logic               result_valid,
    input  logic               result_ready,
    output via_pkg::out_item_t result
);
    import via_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t result_reg;

    // Room for a new result when empty or when the held one is taken now
    assign space = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && space)
            result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== src/versatile_interface_adapter_regs_top.sv =====
// Path: a beat accepted into the input register moves on to the result register once that has room.
// Throughput: one beat per cycle unless results stall; input and result registers each take a beat
// while the other side stalls, and the register file updates as a beat enters the result register.
// Reset: rst_n clears all adapter registers and both stage valids at once.
// Ready follows from the result register's free space through the input stage.
module versatile_interface_adapter_regs_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  via_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output via_pkg::out_item_t result
);
    import via_pkg::*;

    logic      stage_valid;
    in_item_t  stage_item;
    logic      space;
    logic      take;
    out_item_t result_next;

    // Advance the held beat when the result register has room
    assign take = stage_valid && space;

    via_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .take       (take),
        .stage_valid(stage_valid),
        .stage_item (stage_item)
    );

    via_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (take),
        .item       (stage_item),
        .result_next(result_next)
    );

    via_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .result_next (result_next),
        .space       (space),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

// ===== src/via_checker.sv =====
// Port-level checker for the interface adapter, bound to the top level.
module via_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  via_pkg::in_item_t  item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  via_pkg::out_item_t result
);
    import via_pkg::*;

    // Hold a stalled input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("input beat changed while stalled");

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Unimplemented register reads back zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_register |-> result.read_data == 8'h00)
        else $error("bad register access returned data");

    // A CA1 request never comes with a release or a bad register
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.irq_request |->
            !result.irq_release && !result.bad_register)
        else $error("irq request mixed with bus access flags");

    // A release only comes from a valid port A access
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.irq_release |-> !result.bad_register)
        else $error("release on bad register access");

endmodule

bind versatile_interface_adapter_regs_top via_checker u_via_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

// ===== tb/sv/versatile_interface_adapter_regs_top_tb.sv =====
// Self-checking testbench for the register-bus interface adapter with port, flag and enable logic.
module versatile_interface_adapter_regs_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import via_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_ACCESS = 1900;

    // Track adapter registers and hold the results the bus should return
    class adapter_scoreboard;
        logic [7:0] port_a;
        logic [7:0] port_b;
        logic [7:0] dir_a;
        logic [7:0] dir_b;
        logic [7:0] pcr;
        logic [7:0] ifr;
        logic [7:0] ier;
        out_item_t  pending_results[$];
        int         failures;
        int         accesses_noted;
        int         results_checked;
        int         requests_seen;
        int         releases_seen;
        int         bad_seen;

        function new();
            port_a = '0;
            port_b = '0;
            dir_a  = '0;
            dir_b  = '0;
            pcr    = '0;
            ifr    = '0;
            ier    = '0;
            failures        = 0;
            accesses_noted  = 0;
            results_checked = 0;
            requests_seen   = 0;
            releases_seen   = 0;
            bad_seen        = 0;
        endfunction

        // Drop the CA1 and IRQ flags when both are up; report whether that happened
        function logic clear_ca1();
            if ((ifr & FLAG_IRQ_CA1) == FLAG_IRQ_CA1)
            begin
                ifr = ifr & FLAG_KEEP;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advance the register state by one access and return its result
        function out_item_t predict_access(in_item_t acc);
            out_item_t r;
            r = '0;
            case (acc.func)
                FUNC_WRITE:
                begin
                    case (acc.reg_addr)
                        ADDR_PORT_B: port_b = acc.data & dir_b;
                        ADDR_PORT_A:
                        begin
                            port_a = acc.data & dir_a;
                            r.irq_release = clear_ca1();
                        end
                        ADDR_DIR_B: dir_b = acc.data;
                        ADDR_DIR_A: dir_a = acc.data;
                        ADDR_PCR:   pcr = acc.data;
                        ADDR_IFR:   ifr = acc.data;
                        ADDR_IER:
                        begin
                            if (acc.data[IER_SET_BIT])
                                ier = ier | acc.data;
                            else
                                ier = ier & ~acc.data;
                        end
                        default: r.bad_register = 1'b1;
                    endcase
                end
                FUNC_READ:
                begin
                    case (acc.reg_addr)
                        ADDR_PORT_B: r.read_data = port_b & ~dir_b;
                        ADDR_PORT_A:
                        begin
                            r.irq_release = clear_ca1();
                            r.read_data = port_a & ~dir_a;
                        end
                        ADDR_DIR_B: r.read_data = dir_b;
                        ADDR_DIR_A: r.read_data = dir_a;
                        ADDR_PCR:   r.read_data = pcr;
                        ADDR_IFR:   r.read_data = ifr;
                        ADDR_IER:   r.read_data = ier;
                        default:    r.bad_register = 1'b1;
                    endcase
                end
                FUNC_PIN_A: port_a = acc.data & ~dir_a;
                FUNC_PIN_B: port_b = acc.data & ~dir_b;
                FUNC_CA1:
                begin
                    if (acc.data[0] == pcr[0] && (ier & ENABLE_CA1) != '0)
                    begin
                        ifr = ifr | FLAG_IRQ_CA1;
                        r.irq_request = 1'b1;
                    end
                end
                default: ;
            endcase
            r.port_a_out = port_a;
            r.port_b_out = port_b;
            return r;
        endfunction

        function void note_access(in_item_t acc);
            pending_results.push_back(predict_access(acc));
            accesses_noted++;
        endfunction

        function void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
            if (exp_val !== got_val)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %02h, got %02h",
                         $time, name, exp_val, got_val);
            end
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: result %h arrived with nothing expected, expected none",
                         $time, got);
                return;
            end
            exp_r = pending_results.pop_front();
            results_checked++;
            if (exp_r.irq_request)  requests_seen++;
            if (exp_r.irq_release)  releases_seen++;
            if (exp_r.bad_register) bad_seen++;
            compare_field("read_data", exp_r.read_data, got.read_data);
            compare_field("port_a_out", exp_r.port_a_out, got.port_a_out);
            compare_field("port_b_out", exp_r.port_b_out, got.port_b_out);
            compare_field("irq_request", 8'(exp_r.irq_request), 8'(got.irq_request));
            compare_field("irq_release", 8'(exp_r.irq_release), 8'(got.irq_release));
            compare_field("bad_register", 8'(exp_r.bad_register), 8'(got.bad_register));
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;
    int        cycle_count = 0;

    adapter_scoreboard sb = new();

    versatile_interface_adapter_regs_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result side on a pattern that rotates through four ready schemes
    always @(posedge clk)
    begin
        case ((cycle_count / 400) % 4)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 3) != 0);
            2: result_ready <= ((cycle_count % 7) < 3);
            default: result_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watch both channels and feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(result);
            if (item_valid && item_ready)
                sb.note_access(item);
        end
    end

    // Present one access and hold it until accepted
    task automatic send_access(in_item_t acc);
        item       <= acc;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(logic [2:0] f, logic [3:0] a, logic [7:0] d);
        in_item_t acc;
        acc.func     = f;
        acc.reg_addr = a;
        acc.data     = d;
        send_access(acc);
    endtask

    task automatic idle_sender(int cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [3:0] pick_register();
        case ($urandom_range(0, 6))
            0: return ADDR_PORT_B;
            1: return ADDR_PORT_A;
            2: return ADDR_DIR_B;
            3: return ADDR_DIR_A;
            4: return ADDR_PCR;
            5: return ADDR_IFR;
            default: return ADDR_IER;
        endcase
    endfunction

    function automatic logic [3:0] pick_bad_register();
        if ($urandom_range(0, 3) == 0)
            return 4'(ADDR_IER + 1);
        return 4'($urandom_range(ADDR_DIR_A + 1, ADDR_PCR - 1));
    endfunction

    // Build a random access, weighted toward real register traffic and CA1 events
    function automatic in_item_t random_access();
        in_item_t acc;
        int       roll;
        acc.data     = 8'($urandom_range(0, 255));
        acc.reg_addr = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 28)
        begin
            acc.func     = FUNC_WRITE;
            acc.reg_addr = pick_register();
            // bias IER writes toward setting the CA1 enable
            if (acc.reg_addr == ADDR_IER && $urandom_range(0, 1) == 1)
                acc.data = acc.data | FLAG_IRQ_CA1;
        end
        else if (roll < 50)
        begin
            acc.func     = FUNC_READ;
            acc.reg_addr = pick_register();
        end
        else if (roll < 60)
            acc.func = FUNC_PIN_A;
        else if (roll < 68)
            acc.func = FUNC_PIN_B;
        else if (roll < 87)
            acc.func = FUNC_CA1;
        else if (roll < 95)
        begin
            acc.func     = ($urandom_range(0, 1) == 1) ? FUNC_WRITE : FUNC_READ;
            acc.reg_addr = pick_bad_register();
        end
        else
            acc.func = 3'($urandom_range(FUNC_CA1 + 1, 7));
        return acc;
    endfunction

    initial
    begin
        in_item_t acc;
        int       burst_left;
        int       i;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, direction masking, IER set and clear, CA1 flow, bad codes
        send_fields(FUNC_READ,  ADDR_IFR,    8'h00);
        send_fields(FUNC_READ,  ADDR_IER,    8'h00);
        send_fields(FUNC_WRITE, ADDR_DIR_A,  8'hF0);
        send_fields(FUNC_WRITE, ADDR_DIR_B,  8'h0F);
        send_fields(FUNC_WRITE, ADDR_PORT_A, 8'hFF);
        send_fields(FUNC_WRITE, ADDR_PORT_B, 8'hFF);
        send_fields(FUNC_PIN_A, ADDR_PORT_B, 8'hFF);
        send_fields(FUNC_PIN_B, ADDR_PORT_B, 8'hAA);
        send_fields(FUNC_READ,  ADDR_PORT_A, 8'h00);
        send_fields(FUNC_READ,  ADDR_PORT_B, 8'h00);
        send_fields(FUNC_WRITE, ADDR_IER,    8'h82);
        send_fields(FUNC_WRITE, ADDR_PCR,    8'h01);
        send_fields(FUNC_CA1,   ADDR_PORT_B, 8'hFE);
        send_fields(FUNC_CA1,   ADDR_PORT_B, 8'h01);
        send_fields(FUNC_PIN_A, ADDR_PORT_B, 8'h00);
        send_fields(FUNC_READ,  ADDR_IFR,    8'h00);
        send_fields(FUNC_READ,  ADDR_PORT_A, 8'h00);
        send_fields(FUNC_WRITE, ADDR_IFR,    8'hFF);
        send_fields(FUNC_WRITE, ADDR_PCR,    8'hFE);
        send_fields(FUNC_READ,  ADDR_IFR,    8'h00);
        send_fields(FUNC_WRITE, ADDR_PORT_A, 8'h00);
        send_fields(FUNC_WRITE, ADDR_IER,    8'h7F);
        send_fields(FUNC_CA1,   ADDR_PORT_B, 8'h00);
        send_fields(FUNC_WRITE, 4'(ADDR_IER + 1), 8'h55);
        send_fields(FUNC_READ,  4'(ADDR_DIR_A + 1), 8'h00);
        send_fields(3'(FUNC_CA1 + 1), ADDR_PORT_A, 8'h80);
        send_fields(3'(FUNC_CA1 + 3), ADDR_IER, 8'hFF);

        // Random: bursts with gaps, with every other stretch running back to back
        burst_left = $urandom_range(1, 16);
        for (i = 0; i < RANDOM_ACCESS; i++)
        begin
            acc = random_access();
            send_access(acc);
            if ((i / 300) % 2 == 1)
                continue;
            burst_left--;
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 5));
                burst_left = $urandom_range(1, 16);
            end
        end
        item_valid <= 1'b0;

        // Drain and let any stray beat show up
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (sb.pending_results.size() != 0)
        begin
            sb.failures++;
            $display("%0t: %0d results still expected, got none", $time,
                     sb.pending_results.size());
        end

        $display("Checked %0d results from %0d accesses over %0d cycles.",
                 sb.results_checked, sb.accesses_noted, cycle_count);
        $display("Saw %0d interrupt requests, %0d releases, %0d bad-register accesses.",
                 sb.requests_seen, sb.releases_seen, sb.bad_seen);
        if (sb.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/via_pkg.sv
src/via_in_reg.sv
src/via_core.sv
src/via_out_reg.sv
src/versatile_interface_adapter_regs_top.sv
src/via_checker.sv
tb/sv/versatile_interface_adapter_regs_top_tb.sv
